/* sv/rlc_pdu_segment_concat_planner_unit_macros.svh */
// assertion helpers used by the planner back end
`ifndef RLC_PDU_SEGMENT_CONCAT_PLANNER_UNIT_MACROS_SVH
`define RLC_PDU_SEGMENT_CONCAT_PLANNER_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RPSCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen
`define RPSCP_ASSERT_NEVER(name, cond, msg) \
  `RPSCP_ASSERT(name, !(cond), msg)

`endif

/* sv/rpscp_pkg.sv */
package rpscp_pkg;

  // sizes
  localparam int QueueDepth  = 64;
  localparam int QIdxW       = 6;
  localparam int MaxLi       = 24;
  localparam int MaxResults  = 50;
  localparam int LiBufDepth  = 32;
  localparam int SegBufDepth = 64;

  // input modes
  localparam logic [1:0] ModeEnq   = 2'd0;
  localparam logic [1:0] ModeBuild = 2'd1;
  localparam logic [1:0] ModeReset = 2'd2;

  // result kinds
  localparam logic [1:0] KindLi  = 2'd0;
  localparam logic [1:0] KindSeg = 2'd1;
  localparam logic [1:0] KindSum = 2'd2;
  localparam logic [1:0] KindEnq = 2'd3;

  // length indicator codes
  localparam logic [14:0] LiZero  = 15'h0000;
  localparam logic [14:0] LiSplit = 15'h7ffb;
  localparam logic [14:0] LiStart = 15'h7ffc;
  localparam logic [14:0] LiPad   = 15'h7fff;

  // leftover states
  localparam logic [1:0] LoNone  = 2'd0;
  localparam logic [1:0] LoZero  = 2'd1;
  localparam logic [1:0] LoSplit = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CfgLiBytes = 3'd0;
  localparam logic [2:0] CfgUmMode  = 3'd1;
  localparam logic [2:0] CfgDiscSig = 3'd2;
  localparam logic [2:0] CfgNoConc  = 3'd3;
  localparam logic [2:0] CfgOneSdu  = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] sdu_bytes;
    logic        sdu_discarded;
    logic [12:0] pdu_bytes;
    logic [2:0]  header_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [14:0] li_value;
    logic        more_li;
    logic [15:0] segment_bytes;
    logic        segment_ends_sdu;
    logic [12:0] padding_start;
    logic [12:0] padding_li_offset;
    logic [12:0] pad_bytes;
    logic        new_sdu;
    logic        discard_seen;
    logic        enqueue_accepted;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [1:0] data;
    logic       valid;
  } cfg_wr_t;

endpackage

/* sv/rpscp_front.sv */
module rpscp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  rpscp_pkg::in_item_t  in_item_i,
  input  logic                 cmd_pop_i,
  output logic                 cmd_valid_o,
  output rpscp_pkg::in_item_t  cmd_o
);
  import rpscp_pkg::*;

  in_item_t   buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       take, store, drain;

  // accept a beat, keep only known commands
  assign full  = (cnt_q == 2'd2);
  assign take  = push && !full;
  assign store = take && (in_item_i.mode == ModeEnq || in_item_i.mode == ModeBuild ||
                          in_item_i.mode == ModeReset);
  assign drain = cmd_pop_i && (cnt_q != 2'd0);

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    wr_d  = store ? ~wr_q : wr_q;
    rd_d  = drain ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, store} - {1'b0, drain};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (store) begin
      buf_q[wr_q] <= in_item_i;
    end
  end

endmodule

/* sv/rpscp_outq.sv */
module rpscp_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_push_i,
  input  rpscp_pkg::out_item_t res_i,
  output logic                 res_full_o,
  output logic                 empty,
  input  logic                 pop,
  output rpscp_pkg::out_item_t out_item_o
);
  import rpscp_pkg::*;

  out_item_t  buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  // two-entry result queue
  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop && !empty;
  assign out_item_o = buf_q[rd_q];

  always_comb begin
    wr_d  = wr_en ? ~wr_q : wr_q;
    rd_d  = rd_en ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_q] <= res_i;
    end
  end

endmodule

/* sv/rpscp_back.sv */
`include "rlc_pdu_segment_concat_planner_unit_macros.svh"

module rpscp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rpscp_pkg::cfg_wr_t   cfg_i,
  input  logic                 cmd_valid_i,
  input  rpscp_pkg::in_item_t  cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output rpscp_pkg::out_item_t res_o
);
  import rpscp_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SPre   = 4'd1;
  localparam logic [3:0] SRd    = 4'd2;
  localparam logic [3:0] SEv    = 4'd3;
  localparam logic [3:0] SFc    = 4'd4;
  localparam logic [3:0] SFit   = 4'd5;
  localparam logic [3:0] SPad   = 4'd6;
  localparam logic [3:0] SLiRd  = 4'd7;
  localparam logic [3:0] SLiWr  = 4'd8;
  localparam logic [3:0] SSgRd  = 4'd9;
  localparam logic [3:0] SSgWr  = 4'd10;
  localparam logic [3:0] SSum   = 4'd11;
  localparam logic [3:0] SUnder = 4'd12;
  localparam logic [3:0] SEnq   = 4'd13;

  // configuration
  logic [1:0] li_bytes_q;
  logic       um_q, ds_q, nc_q, one_q;
  logic [1:0] lib;
  logic signed [14:0] lib_s;

  // sdu queue
  logic [15:0] size_mem [QueueDepth];
  logic        disc_mem [QueueDepth];
  logic [15:0] rd_size_q;
  logic        rd_disc_q;
  logic [QIdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [QIdxW:0]   count_q, count_d;
  logic        split_q, split_d;
  logic [1:0]  leftover_q, leftover_d;

  // build working registers
  logic [3:0]  state_q, state_d;
  logic signed [14:0] rem_q, rem_d;
  logic [1:0]  lo_q, lo_d;
  logic [QIdxW-1:0] pos_q, pos_d;
  logic [QIdxW:0]   left_q, left_d, rmv_q, rmv_d;
  logic [5:0]  nli_q, nli_d, nseg_q, nseg_d, idx_q, idx_d;
  logic        newsdu_q, newsdu_d, disc_q, disc_d, fsplit_q, fsplit_d;
  logic        enq_ok_q, enq_ok_d;
  logic [12:0] fbytes_q, fbytes_d, pstart_q, pstart_d, poff_q, poff_d;
  logic [12:0] pdu_q, pdu_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [15:0] sz_q, sz_d;

  // plan buffers
  logic [14:0] li_mem [LiBufDepth];
  logic [16:0] seg_mem [SegBufDepth];
  logic [14:0] li_rd_q;
  logic [16:0] seg_rd_q;

  // write ports
  logic        q_we, q_wdisc;
  logic [QIdxW-1:0] q_wa;
  logic [15:0] q_wsz;
  logic        li_we, seg_we;
  logic [4:0]  li_wa;
  logic [14:0] li_wd;
  logic [5:0]  seg_wa;
  logic [16:0] seg_wd;

  assign lib   = (li_bytes_q == 2'd1) ? 2'd1 : 2'd2;
  assign lib_s = $signed({13'd0, lib});

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      li_bytes_q <= 2'd2;
      um_q       <= 1'b1;
      ds_q       <= 1'b0;
      nc_q       <= 1'b0;
      one_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgLiBytes: li_bytes_q <= cfg_i.data;
        CfgUmMode:  um_q       <= cfg_i.data[0];
        CfgDiscSig: ds_q       <= cfg_i.data[0];
        CfgNoConc:  nc_q       <= cfg_i.data[0];
        CfgOneSdu:  one_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    logic signed [16:0] sz17, rem17;
    logic signed [14:0] rem_n;
    logic [5:0]  nli_n, nseg_n;
    logic [6:0]  li_chk, res_chk;
    logic        brk, fs_n;
    logic [12:0] off;

    sz17 = $signed({1'b0, sz_q});
    rem17 = {{2{rem_q[14]}}, rem_q};
    rem_n = rem_q;
    nli_n = nli_q;
    nseg_n = nseg_q;
    li_chk = '0;
    res_chk = '0;
    brk = 1'b0;
    fs_n = 1'b0;
    off = '0;

    state_d = state_q;
    head_d = head_q; tail_d = tail_q; count_d = count_q;
    split_d = split_q; leftover_d = leftover_q;
    rem_d = rem_q; lo_d = lo_q; pos_d = pos_q; left_d = left_q; rmv_d = rmv_q;
    nli_d = nli_q; nseg_d = nseg_q; idx_d = idx_q;
    newsdu_d = newsdu_q; disc_d = disc_q; fsplit_d = fsplit_q; enq_ok_d = enq_ok_q;
    fbytes_d = fbytes_q; pstart_d = pstart_q; poff_d = poff_q;
    pdu_d = pdu_q; hdr_d = hdr_q; sz_d = sz_q;

    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o = '0;
    q_we = 1'b0; q_wa = tail_q; q_wsz = cmd_i.sdu_bytes; q_wdisc = cmd_i.sdu_discarded;
    li_we = 1'b0; li_wa = nli_q[4:0]; li_wd = LiPad;
    seg_we = 1'b0; seg_wa = nseg_q; seg_wd = '0;

    unique case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.mode)
            ModeEnq: begin
              enq_ok_d = (count_q < (QIdxW+1)'(QueueDepth)) && (cmd_i.sdu_bytes != 16'd0);
              if (enq_ok_d) begin
                q_we = 1'b1;
                tail_d = tail_q + 1'b1;
                count_d = count_q + 1'b1;
              end
              state_d = SEnq;
            end
            ModeBuild: begin
              rem_d = $signed({2'b0, cmd_i.pdu_bytes}) - $signed({12'd0, cmd_i.header_bytes});
              pdu_d = cmd_i.pdu_bytes;
              hdr_d = cmd_i.header_bytes;
              lo_d = leftover_q;
              pos_d = head_q;
              left_d = count_q;
              rmv_d = '0;
              nli_d = '0;
              nseg_d = '0;
              newsdu_d = (count_q != '0) && !split_q;
              disc_d = 1'b0;
              fsplit_d = 1'b0;
              fbytes_d = '0;
              pstart_d = '0;
              poff_d = '0;
              state_d = SPre;
            end
            default: begin
              // transmit side reset
              leftover_d = LoNone;
              if (split_q && count_q != '0) begin
                head_d = head_q + 1'b1;
                count_d = count_q - 1'b1;
              end
              split_d = 1'b0;
            end
          endcase
        end
      end

      SPre: begin
        // pending leftover with nothing queued
        if (left_q == '0 && lo_q != LoNone) begin
          li_we = 1'b1;
          li_wd = (lo_q == LoZero) ? LiZero : LiSplit;
          rem_n = rem_q - lib_s;
          nli_d = nli_q + 1'b1;
          lo_d = LoNone;
        end
        rem_d = rem_n;
        if (rem_n < 0) begin
          state_d = SUnder;
        end else if (left_q != '0) begin
          state_d = SRd;
        end else begin
          state_d = SPad;
        end
      end

      SRd: state_d = SEv;

      SEv: begin
        sz_d = rd_size_q;
        if (rd_disc_q) begin
          // discarded entry is skipped, unless a discard signal ends a plan that already holds segments
          if (um_q && !disc_q) begin
            disc_d = 1'b1;
            if (ds_q) begin
              if (nseg_q != '0) begin
                brk = 1'b1;
              end else begin
                lo_d = LoZero;
              end
            end
          end
          if (brk) begin
            state_d = SPad;
          end else begin
            rmv_d = rmv_q + 1'b1;
            pos_d = pos_q + 1'b1;
            left_d = left_q - 1'b1;
            state_d = (one_q || left_q == (QIdxW+1)'(1)) ? SPad : SRd;
          end
        end else begin
          if (lo_q != LoNone) begin
            li_we = 1'b1;
            li_wd = (lo_q == LoZero) ? LiZero : LiSplit;
            rem_d = rem_q - lib_s;
            nli_d = nli_q + 1'b1;
            lo_d = LoNone;
          end
          state_d = SFc;
        end
      end

      SFc: begin
        // start-of-sdu marker in UM
        if (um_q && nli_q == '0 && newsdu_q) begin
          li_we = 1'b1;
          li_wd = LiStart;
          rem_d = rem_q - lib_s;
          nli_d = nli_q + 1'b1;
        end
        state_d = SFit;
      end

      SFit: begin
        if (rem_q < 0) begin
          state_d = SUnder;
        end else begin
          if (sz17 > rem17) begin
            fs_n = 1'b1;
            fbytes_d = rem_q[12:0];
            rem_n = '0;
          end else if (sz17 == rem17) begin
            lo_d = LoZero;
            rem_n = '0;
          end else if (lib == 2'd2 && sz17 == rem17 - 17'sd1) begin
            lo_d = LoSplit;
            rem_n = 15'sd1;
          end else if (lib == 2'd2 && sz17 == rem17 - 17'sd3) begin
            li_we = 1'b1;
            li_wd = sz_q[14:0];
            nli_n = nli_q + 1'b1;
            rem_n = 15'sd1;
          end else begin
            li_we = 1'b1;
            li_wd = sz_q[14:0];
            nli_n = nli_q + 1'b1;
            rem_n = rem_q - lib_s - $signed({2'b0, sz_q[12:0]});
          end
          fsplit_d = fs_n;
          seg_we = 1'b1;
          seg_wd = fs_n ? {1'b0, 3'b0, rem_q[12:0]} : {1'b1, sz_q};
          nseg_n = nseg_q + 1'b1;
          if (!fs_n) begin
            rmv_d = rmv_q + 1'b1;
          end
          pos_d = pos_q + 1'b1;
          left_d = left_q - 1'b1;
          rem_d = rem_n;
          nli_d = nli_n;
          nseg_d = nseg_n;
          li_chk = {1'b0, nli_n} + 7'd2;
          res_chk = {1'b0, nli_n} + {1'b0, nseg_n} + 7'd4;
          if (rem_n <= lib_s || nc_q || one_q || li_chk > 7'(MaxLi) ||
              res_chk > 7'(MaxResults) || left_q == (QIdxW+1)'(1)) begin
            state_d = SPad;
          end else begin
            state_d = SRd;
          end
        end
      end

      SPad: begin
        // padding indicator if there is room for one, then commit the plan
        if (rem_q >= lib_s) begin
          off = (lib == 2'd1) ? {7'd0, nli_q} : {6'd0, nli_q, 1'b0};
          poff_d = {10'd0, hdr_q} + off;
          pstart_d = pdu_q - rem_q[12:0];
          li_we = 1'b1;
          li_wd = LiPad;
          nli_n = nli_q + 1'b1;
          rem_d = rem_q - lib_s;
        end
        nli_d = nli_n;
        head_d = head_q + rmv_q[QIdxW-1:0];
        count_d = count_q - rmv_q;
        split_d = fsplit_q;
        leftover_d = lo_q;
        if (fsplit_q) begin
          q_we = 1'b1;
          q_wa = head_q + rmv_q[QIdxW-1:0];
          q_wsz = sz_q - {3'b0, fbytes_q};
          q_wdisc = 1'b0;
        end
        idx_d = '0;
        if (nli_n != '0) begin
          state_d = SLiRd;
        end else if (nseg_q != '0) begin
          state_d = SSgRd;
        end else begin
          state_d = SSum;
        end
      end

      SLiRd: state_d = SLiWr;

      SLiWr: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = KindLi;
          res_o.li_value = (lib == 2'd1) ? {8'd0, li_rd_q[6:0]} : li_rd_q;
          res_o.more_li = (idx_q != nli_q - 1'b1);
          if (idx_q == nli_q - 1'b1) begin
            idx_d = '0;
            state_d = (nseg_q != '0) ? SSgRd : SSum;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = SLiRd;
          end
        end
      end

      SSgRd: state_d = SSgWr;

      SSgWr: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = KindSeg;
          res_o.segment_bytes = seg_rd_q[15:0];
          res_o.segment_ends_sdu = seg_rd_q[16];
          if (idx_q == nseg_q - 1'b1) begin
            idx_d = '0;
            state_d = SSum;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = SSgRd;
          end
        end
      end

      SSum: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = KindSum;
          res_o.padding_start = pstart_q;
          res_o.padding_li_offset = poff_q;
          res_o.pad_bytes = rem_q[12:0];
          res_o.new_sdu = newsdu_q;
          res_o.discard_seen = disc_q;
          res_o.last = 1'b1;
          state_d = SIdle;
        end
      end

      SUnder: begin
        // undersized pdu: empty summary, state untouched
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = KindSum;
          res_o.last = 1'b1;
          state_d = SIdle;
        end
      end

      SEnq: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = KindEnq;
          res_o.enqueue_accepted = enq_ok_q;
          res_o.last = 1'b1;
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      split_q    <= 1'b0;
      leftover_q <= LoNone;
      nli_q      <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      split_q    <= split_d;
      leftover_q <= leftover_d;
      nli_q      <= nli_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    lo_q     <= lo_d;
    pos_q    <= pos_d;
    left_q   <= left_d;
    rmv_q    <= rmv_d;
    nseg_q   <= nseg_d;
    idx_q    <= idx_d;
    newsdu_q <= newsdu_d;
    disc_q   <= disc_d;
    fsplit_q <= fsplit_d;
    enq_ok_q <= enq_ok_d;
    fbytes_q <= fbytes_d;
    pstart_q <= pstart_d;
    poff_q   <= poff_d;
    pdu_q    <= pdu_d;
    hdr_q    <= hdr_d;
    sz_q     <= sz_d;
  end

  // sdu length memory
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      size_mem[q_wa] <= q_wsz;
      disc_mem[q_wa] <= q_wdisc;
    end
    rd_size_q <= size_mem[pos_q];
    rd_disc_q <= disc_mem[pos_q];
  end

  // plan buffers
  always_ff @(posedge clk_i) begin
    if (li_we) begin
      li_mem[li_wa] <= li_wd;
    end
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    li_rd_q  <= li_mem[idx_q[4:0]];
    seg_rd_q <= seg_mem[idx_q];
  end

  `RPSCP_ASSERT(a_count_bound, count_q <= (QIdxW+1)'(QueueDepth), "queue count over depth")
  `RPSCP_ASSERT(a_ptr_track, (head_q + count_q[QIdxW-1:0]) == tail_q, "queue pointers disagree")
  `RPSCP_ASSERT_NEVER(a_push_full, res_push_o && res_full_i, "result beat pushed into full queue")
  `RPSCP_ASSERT(a_li_bound, nli_q < 6'(LiBufDepth), "length indicator buffer overrun")

endmodule

/* sv/rlc_pdu_segment_concat_planner_unit.sv */
// channel   direction  handshake                    payload
// input     in         push / full                  in_item_i  (in_item_t)
// result    out        empty / pop                  out_item_o (out_item_t)
// config    in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// enqueue: SEnq builds the status beat and pushes it into the result queue
// build: SPre decodes; SRd, SEv, SFc, SFit per sdu walked (SRd, SEv if discarded);
//   SPad commits; SLiRd/SLiWr per LI beat, SSgRd/SSgWr per segment; SSum summary
// reset: no clearing pass; the block accepts beats right after reset
// the front takes up to two commands while the back works or the result side stalls
module rlc_pdu_segment_concat_planner_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  rpscp_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output rpscp_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [1:0]           cfg_data_i
);
  import rpscp_pkg::*;

  logic      cmd_valid, cmd_pop, res_push, res_full;
  in_item_t  cmd;
  out_item_t res;
  cfg_wr_t   cfg;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  rpscp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  rpscp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  rpscp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule
